// ===== sv/rail_fence_block_cipher_unit_macros.svh =====
// Assertion helpers shared by the rail fence unit.
`ifndef RAIL_FENCE_BLOCK_CIPHER_UNIT_MACROS_SVH
`define RAIL_FENCE_BLOCK_CIPHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge outside reset.
`define RFBC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RFBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RFBC_ASSERT(lbl, clk, rst, prop, msg)
`define RFBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/rfbc_pkg.sv =====
package rfbc_pkg;

  // Block store depth default
  localparam int BLOCK_LEN_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int RAIL_W = 7;
  // Zigzag step is twice a rail distance, so one bit wider than a rail
  localparam int STEP_W = RAIL_W + 1;

  localparam logic [RAIL_W-1:0] RAIL_MIN = 7'd2;
  localparam logic [RAIL_W-1:0] RAIL_MAX = 7'd100;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b1;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // Control from the sequencer to the zigzag walker
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctrl_t;

endpackage

// ===== sv/rfbc_ifs.sv =====
// Input byte channel
interface rfbc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rfbc_pkg::BYTE_W-1:0] data_byte;
  logic                       end_of_block;

  modport source (output valid, output data_byte, output end_of_block, input ready);
  modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

// Permuted byte channel
interface rfbc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rfbc_pkg::BYTE_W-1:0] out_byte;
  logic                       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// Register write channel
interface rfbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rfbc_pkg::CFG_IDX_W-1:0]  index;
  logic [rfbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rfbc_walk.sv =====
// Enumerates block positions rail by rail. Each step yields the next
// position (pos) and its running order number (idx). Within a rail the
// positions advance by alternating strides 2*(R-1-r) and 2*r.
module rfbc_walk #(
  parameter int BLOCK_LEN = rfbc_pkg::BLOCK_LEN_DEF,
  localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1,
  localparam int CW = $clog2(BLOCK_LEN + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rfbc_pkg::walk_ctrl_t            ctrl,
  input  logic [rfbc_pkg::RAIL_W-1:0]     rail_count,
  input  logic [CW-1:0]                   blk_len,
  output logic [AW-1:0]                   pos,
  output logic [AW-1:0]                   idx,
  output logic                            last
);

  localparam int SW    = rfbc_pkg::STEP_W;
  localparam int SUM_W = ((AW > SW) ? AW : SW) + 1;

  logic [AW-1:0]    rail;
  logic             use_b;
  logic [SW-1:0]    rail_ext;
  logic [SW-1:0]    span;
  logic [SW-1:0]    step_a;
  logic [SW-1:0]    step_b;
  logic [SW-1:0]    stride;
  logic [SUM_W-1:0] sum;
  logic             in_rail;

  // Stride selection: outer rails have one non-zero stride only
  always_comb begin
    rail_ext = SW'(rail);
    span     = {1'b0, rail_count} - SW'(1) - rail_ext;
    step_a   = span << 1;
    step_b   = rail_ext << 1;
    if (step_a == '0) begin
      stride = step_b;
    end else if (step_b == '0) begin
      stride = step_a;
    end else begin
      stride = use_b ? step_b : step_a;
    end
    sum     = SUM_W'(pos) + SUM_W'(stride);
    in_rail = sum < SUM_W'(blk_len);
  end

  assign last = (CW'(idx) == blk_len - CW'(1));

  // Walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rail  <= '0;
      pos   <= '0;
      idx   <= '0;
      use_b <= 1'b0;
    end else if (ctrl.start) begin
      rail  <= '0;
      pos   <= '0;
      idx   <= '0;
      use_b <= 1'b0;
    end else if (ctrl.step) begin
      idx <= idx + AW'(1);
      if (in_rail) begin
        pos   <= sum[AW-1:0];
        use_b <= !use_b;
      end else begin
        // next rail is always populated while items remain
        rail  <= rail + AW'(1);
        pos   <= rail + AW'(1);
        use_b <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/rail_fence_block_cipher_unit.sv =====
// Rail fence block permuter. Bytes of a block are taken one per cycle into
// a BLOCK_LEN-byte memory until the item marked end_of_block, or the item
// that fills the memory. The rail count (2..100; other writes are ignored)
// and direction are sampled at that item, and the block then streams out
// zigzag-permuted. Encrypt: each byte is read from the memory into the
// output register, and the next read is issued only once that byte has
// landed there and the output is free or taken. Decrypt first runs a pass
// that scatters the bytes into a second memory, then streams that memory
// out in order in the same way. The next block is taken once the last read
// of the previous one has been issued; configure only while idle.
`include "rail_fence_block_cipher_unit_macros.svh"

module rail_fence_block_cipher_unit #(
  parameter int BLOCK_LEN = rfbc_pkg::BLOCK_LEN_DEF,
  localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1,
  localparam int CW = $clog2(BLOCK_LEN + 1)
) (
  input  logic        clk,
  input  logic        rst,
  rfbc_in_if.sink     feed,
  rfbc_out_if.source  result,
  rfbc_cfg_if.sink    cfg
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_ENC  = 2'd1;
  localparam logic [1:0] ST_PERM = 2'd2;
  localparam logic [1:0] ST_DEC  = 2'd3;

  localparam int BW = rfbc_pkg::BYTE_W;

  logic [1:0]                  state;
  logic [AW-1:0]               fill;
  logic [CW-1:0]               blk_len;
  logic [rfbc_pkg::RAIL_W-1:0] rails;
  logic [rfbc_pkg::RAIL_W-1:0] rail_count;
  logic                        direction;

  logic [BW-1:0] byte_store [BLOCK_LEN];
  logic [BW-1:0] out_store  [BLOCK_LEN];
  logic [BW-1:0] byte_rd;
  logic [BW-1:0] dec_rd;
  logic [AW-1:0] rd_addr;

  logic          rd_pending;
  logic          rd_last;
  logic          rd_sel;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] dec_idx;

  logic          out_valid;
  logic [BW-1:0] out_byte;
  logic          out_last;

  logic                 in_acc;
  logic                 blk_end;
  logic                 can_issue;
  logic                 enc_issue;
  logic                 perm_issue;
  logic                 dec_issue;
  logic                 dec_last;
  rfbc_pkg::walk_ctrl_t walk_ctrl;
  logic [AW-1:0]        walk_pos;
  logic [AW-1:0]        walk_idx;
  logic                 walk_last;

  // Register writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count <= rfbc_pkg::RAIL_MIN;
      direction  <= rfbc_pkg::DIR_ENCRYPT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rfbc_pkg::REG_RAIL_COUNT: begin
          if (cfg.data >= rfbc_pkg::RAIL_MIN && cfg.data <= rfbc_pkg::RAIL_MAX) begin
            rail_count <= cfg.data;
          end
        end
        rfbc_pkg::REG_DIRECTION: begin
          direction <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake and issue conditions
  assign feed.ready = (state == ST_LOAD);
  assign in_acc     = feed.valid && feed.ready;
  assign blk_end    = feed.end_of_block || (fill == AW'(BLOCK_LEN - 1));
  assign can_issue  = !rd_pending && (!out_valid || result.ready);
  assign enc_issue  = (state == ST_ENC) && can_issue;
  assign perm_issue = (state == ST_PERM);
  assign dec_issue  = (state == ST_DEC) && can_issue && !wr_pend;
  assign dec_last   = (CW'(dec_idx) == blk_len - CW'(1));

  assign walk_ctrl.start = in_acc && blk_end;
  assign walk_ctrl.step  = enc_issue || perm_issue;

  rfbc_walk #(.BLOCK_LEN(BLOCK_LEN)) u_walk (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (walk_ctrl),
    .rail_count (rails),
    .blk_len    (blk_len),
    .pos        (walk_pos),
    .idx        (walk_idx),
    .last       (walk_last)
  );

  // Input store: written on load, read by position (encrypt) or order (decrypt)
  assign rd_addr = (state == ST_ENC) ? walk_pos : walk_idx;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_store[fill] <= feed.data_byte;
    end
    byte_rd <= byte_store[rd_addr];
  end

  // Decrypt store: scattered during the permutation pass, read in order
  always_ff @(posedge clk) begin
    if (wr_pend) begin
      out_store[wr_addr] <= byte_rd;
    end
    dec_rd <= out_store[dec_idx];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      fill    <= '0;
      blk_len <= '0;
      rails   <= rfbc_pkg::RAIL_MIN;
      dec_idx <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= perm_issue;
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (blk_end) begin
              fill    <= '0;
              blk_len <= CW'(fill) + CW'(1);
              rails   <= rail_count;
              state   <= (direction == rfbc_pkg::DIR_DECRYPT) ? ST_PERM : ST_ENC;
            end else begin
              fill <= fill + AW'(1);
            end
          end
        end
        ST_ENC: begin
          if (enc_issue && walk_last) begin
            state <= ST_LOAD;
          end
        end
        ST_PERM: begin
          if (walk_last) begin
            dec_idx <= '0;
            state   <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (dec_issue) begin
            dec_idx <= dec_idx + AW'(1);
            if (dec_last) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= enc_issue || dec_issue;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= walk_pos;
    rd_last <= enc_issue ? walk_last : dec_last;
    rd_sel  <= (state == ST_DEC);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pending) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      out_byte <= rd_sel ? dec_rd : byte_rd;
      out_last <= rd_last;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.out_last = out_last;

  // Checks
  `RFBC_ASSERT(a_rd_slot_free, clk, rst, rd_pending |-> !out_valid, "output register busy")
  `RFBC_ASSERT_NEXT(a_rd_lands, clk, rst, rd_pending, out_valid, "read data not loaded")
  `RFBC_ASSERT(a_dec_after_scatter, clk, rst, !(dec_issue && wr_pend), "read overtakes scatter")
  `RFBC_ASSERT_NEXT(a_enc_done, clk, rst, enc_issue && walk_last, state == ST_LOAD, "load missed")

endmodule
